>>> hw/rtl/dtt_pkg.sv
package dtt_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // field widths
   localparam int KEY_W   = 31;
   localparam int TIME_W  = 64;
   localparam int WORD_W  = 32;
   localparam int DELAY_W = 32;
   localparam int ENTRY_W = KEY_W + TIME_W + WORD_W + WORD_W + 1;

   // ms (10 fraction bits) to ns: multiply by 10^6, drop 10 bits
   localparam int           SCALE_W  = 20;
   localparam int           FRAC_W   = 10;
   localparam int           PROD_W   = DELAY_W + SCALE_W;
   localparam logic [SCALE_W-1:0] MS_SCALE = SCALE_W'(1000000);

   // command codes
   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_RUN    = 2'd2;
   localparam logic [1:0] CMD_FINISH = 2'd3;

   // response status codes
   localparam logic [2:0] ST_ADDED   = 3'd0;
   localparam logic [2:0] ST_FULL    = 3'd1;
   localparam logic [2:0] ST_REMOVED = 3'd2;
   localparam logic [2:0] ST_ABSENT  = 3'd3;
   localparam logic [2:0] ST_EMIT    = 3'd4;
   localparam logic [2:0] ST_DONE    = 3'd5;

   // controller to datapath
   typedef struct packed {
      logic             load;
      logic             scan_clr;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             commit;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rsp_last;
   } dp_status_type;

endpackage

>>> hw/rtl/dtt_ram.sv
module dtt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/dtt_ctrl.sv
module dtt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output dtt_pkg::ctrl_cmd_type  cmd,
   input  dtt_pkg::dp_status_type sts
);
   import dtt_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_COMMIT = 2'd2;
   localparam logic [1:0] S_OUT    = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load     = 1'b1;
               cmd.scan_clr = 1'b1;
               cnt_in       = '0;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            // one slot read per cycle, then a final pass for the last compare
            cmd.rd_en   = (cnt_ff < CNT_W'(TABLE_DEPTH));
            cmd.rd_addr = cnt_ff[IDX_W-1:0];
            if (cnt_ff == CNT_W'(TABLE_DEPTH)) begin
               state_in = S_COMMIT;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) begin
               if (sts.rsp_last) begin
                  state_in = S_IDLE;
               end else begin
                  // more entries may be due: scan again
                  cmd.scan_clr = 1'b1;
                  cnt_in       = '0;
                  state_in     = S_SCAN;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request and response open at once");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && sts.rsp_last) |=> req_ready)
      else $error("final transfer did not return to idle");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(TABLE_DEPTH))
      else $error("scan counter out of range");

endmodule

>>> hw/rtl/dtt_datapath.sv
module dtt_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  dtt_pkg::ctrl_cmd_type  cmd,
   output dtt_pkg::dp_status_type sts,
   input  logic [1:0]             req_cmd,
   input  logic [63:0]            req_now_ns,
   input  logic [31:0]            req_delay_ms,
   input  logic [31:0]            req_callback_id,
   input  logic [31:0]            req_user_word,
   input  logic                   req_with_param,
   input  logic [30:0]            req_task_key,
   output logic [2:0]             rsp_status,
   output logic [30:0]            rsp_out_key,
   output logic [31:0]            rsp_out_callback,
   output logic [31:0]            rsp_out_user_word,
   output logic                   rsp_out_with_param,
   output logic                   rsp_last
);
   import dtt_pkg::*;

   // latched request
   logic [1:0]         op_ff;
   logic [TIME_W-1:0]  now_ff;
   logic [DELAY_W-1:0] delay_ff;
   logic [WORD_W-1:0]  cb_ff;
   logic [WORD_W-1:0]  uw_ff;
   logic               wp_ff;
   logic [KEY_W-1:0]   tkey_ff;

   // table state
   logic [TABLE_DEPTH-1:0] slot_valid_ff, slot_valid_in;
   logic [KEY_W-1:0]       next_key_ff, next_key_in;

   // scan results
   logic               ev_ff;
   logic [IDX_W-1:0]   ev_idx_ff;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   found_slot_ff, found_slot_in;
   logic               free_ff, free_in;
   logic [IDX_W-1:0]   free_slot_ff, free_slot_in;
   logic [KEY_W-1:0]   best_key_ff, best_key_in;
   logic [WORD_W-1:0]  best_cb_ff, best_cb_in;
   logic [WORD_W-1:0]  best_uw_ff, best_uw_in;
   logic               best_wp_ff, best_wp_in;

   // deadline arithmetic
   logic [PROD_W-1:0]  prod_ff;
   logic [TIME_W:0]    dl_sum;
   logic [TIME_W-1:0]  deadline;

   // response registers
   logic [2:0]         st_ff, st_in;
   logic [KEY_W-1:0]   okey_ff, okey_in;
   logic [WORD_W-1:0]  ocb_ff, ocb_in;
   logic [WORD_W-1:0]  ouw_ff, ouw_in;
   logic               owp_ff, owp_in;
   logic               olast_ff, olast_in;

   // RAM ports
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] rd_data;
   logic [KEY_W-1:0]   rd_key;
   logic [TIME_W-1:0]  rd_deadline;
   logic [WORD_W-1:0]  rd_cb;
   logic [WORD_W-1:0]  rd_uw;
   logic               rd_wp;
   logic               ev_valid;
   logic               due;

   dtt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (rd_data)
   );

   assign {rd_key, rd_deadline, rd_cb, rd_uw, rd_wp} = rd_data;

   // deadline = now + delay in ns, saturating
   assign dl_sum   = {1'b0, now_ff} + (TIME_W+1)'(prod_ff[PROD_W-1:FRAC_W]);
   assign deadline = dl_sum[TIME_W] ? {TIME_W{1'b1}} : dl_sum[TIME_W-1:0];

   assign ev_valid = slot_valid_ff[ev_idx_ff];
   assign due      = (op_ff == CMD_FINISH) || (now_ff > rd_deadline);

   // per-slot compare during the scan
   always_comb begin
      found_in      = found_ff;
      found_slot_in = found_slot_ff;
      free_in       = free_ff;
      free_slot_in  = free_slot_ff;
      best_key_in   = best_key_ff;
      best_cb_in    = best_cb_ff;
      best_uw_in    = best_uw_ff;
      best_wp_in    = best_wp_ff;
      if (cmd.scan_clr) begin
         found_in = 1'b0;
         free_in  = 1'b0;
      end else if (ev_ff) begin
         unique case (op_ff)
            CMD_ADD: begin
               if (ev_valid && rd_key == next_key_ff && !found_ff) begin
                  found_in      = 1'b1;
                  found_slot_in = ev_idx_ff;
               end
               if (!ev_valid && !free_ff) begin
                  free_in      = 1'b1;
                  free_slot_in = ev_idx_ff;
               end
            end
            CMD_REMOVE: begin
               if (ev_valid && rd_key == tkey_ff) begin
                  found_in      = 1'b1;
                  found_slot_in = ev_idx_ff;
               end
            end
            default: begin
               // run and finish: smallest key among due entries
               if (ev_valid && due && (!found_ff || rd_key < best_key_ff)) begin
                  found_in      = 1'b1;
                  found_slot_in = ev_idx_ff;
                  best_key_in   = rd_key;
                  best_cb_in    = rd_cb;
                  best_uw_in    = rd_uw;
                  best_wp_in    = rd_wp;
               end
            end
         endcase
      end
   end

   // commit: update table and load the response
   always_comb begin
      slot_valid_in = slot_valid_ff;
      next_key_in   = next_key_ff;
      st_in         = st_ff;
      okey_in       = okey_ff;
      ocb_in        = ocb_ff;
      ouw_in        = ouw_ff;
      owp_in        = owp_ff;
      olast_in      = olast_ff;
      wr_en         = 1'b0;
      wr_addr       = found_ff ? found_slot_ff : free_slot_ff;
      wr_data       = {next_key_ff, deadline, cb_ff, (wp_ff ? uw_ff : '0), wp_ff};
      if (cmd.commit) begin
         ocb_in   = '0;
         ouw_in   = '0;
         owp_in   = 1'b0;
         olast_in = 1'b1;
         unique case (op_ff)
            CMD_ADD: begin
               if (found_ff || free_ff) begin
                  wr_en                  = 1'b1;
                  slot_valid_in[wr_addr] = 1'b1;
                  next_key_in            = next_key_ff + KEY_W'(1);
                  st_in                  = ST_ADDED;
                  okey_in                = next_key_ff;
               end else begin
                  st_in   = ST_FULL;
                  okey_in = '0;
               end
            end
            CMD_REMOVE: begin
               okey_in = tkey_ff;
               if (found_ff) begin
                  slot_valid_in[found_slot_ff] = 1'b0;
                  st_in                        = ST_REMOVED;
               end else begin
                  st_in = ST_ABSENT;
               end
            end
            default: begin
               if (found_ff) begin
                  slot_valid_in[found_slot_ff] = 1'b0;
                  st_in    = ST_EMIT;
                  okey_in  = best_key_ff;
                  ocb_in   = best_cb_ff;
                  ouw_in   = best_uw_ff;
                  owp_in   = best_wp_ff;
                  olast_in = 1'b0;
               end else begin
                  st_in   = ST_DONE;
                  okey_in = '0;
               end
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         next_key_ff   <= '0;
         ev_ff         <= 1'b0;
         found_ff      <= 1'b0;
         free_ff       <= 1'b0;
         olast_ff      <= 1'b1;
      end else begin
         slot_valid_ff <= slot_valid_in;
         next_key_ff   <= next_key_in;
         ev_ff         <= cmd.rd_en;
         found_ff      <= found_in;
         free_ff       <= free_in;
         olast_ff      <= olast_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_cmd;
         now_ff   <= req_now_ns;
         delay_ff <= req_delay_ms;
         cb_ff    <= req_callback_id;
         uw_ff    <= req_user_word;
         wp_ff    <= req_with_param;
         tkey_ff  <= req_task_key;
      end
      prod_ff       <= delay_ff * MS_SCALE;
      ev_idx_ff     <= cmd.rd_addr;
      found_slot_ff <= found_slot_in;
      free_slot_ff  <= free_slot_in;
      best_key_ff   <= best_key_in;
      best_cb_ff    <= best_cb_in;
      best_uw_ff    <= best_uw_in;
      best_wp_ff    <= best_wp_in;
      st_ff         <= st_in;
      okey_ff       <= okey_in;
      ocb_ff        <= ocb_in;
      ouw_ff        <= ouw_in;
      owp_ff        <= owp_in;
   end

   assign sts.rsp_last       = olast_ff;
   assign rsp_status         = st_ff;
   assign rsp_out_key        = okey_ff;
   assign rsp_out_callback   = ocb_ff;
   assign rsp_out_user_word  = ouw_ff;
   assign rsp_out_with_param = owp_ff;
   assign rsp_last           = olast_ff;

   a_key_advance: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && op_ff == CMD_ADD && (found_ff || free_ff))
      |=> (next_key_ff == $past(next_key_ff) + KEY_W'(1)))
      else $error("key counter did not advance on add");

endmodule

>>> hw/rtl/deadline_task_table.sv
// Table of up to TABLE_DEPTH pending deadline tasks.
// Request channel (req_*): valid/ready; req_cmd selects add, remove,
// run due entries or finish all. One request is handled at a time;
// req_ready is high only while the block is idle.
// Response channel (rsp_*): valid/ready from output registers. Add and
// remove give one response. Run and finish give one response per
// drained entry in ascending key order, then a done response with
// rsp_last high.
// Scan: every response takes one full scan of the slot RAM, one slot
// read per cycle, then a compare and a commit step before rsp_valid.
// A drain of k entries thus takes k + 1 full scans, plus receiver
// stalls. The single read port of the slot RAM sets this pace.
// Reset empties the table and clears the key counter; no clearing pass.
// When the receiver stalls, the response holds and no new scan starts.
module deadline_task_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [63:0] req_now_ns,
   input  logic [31:0] req_delay_ms,
   input  logic [31:0] req_callback_id,
   input  logic [31:0] req_user_word,
   input  logic        req_with_param,
   input  logic [30:0] req_task_key,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [30:0] rsp_out_key,
   output logic [31:0] rsp_out_callback,
   output logic [31:0] rsp_out_user_word,
   output logic        rsp_out_with_param,
   output logic        rsp_last
);
   import dtt_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type sts;

   dtt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   dtt_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_cmd            (req_cmd),
      .req_now_ns         (req_now_ns),
      .req_delay_ms       (req_delay_ms),
      .req_callback_id    (req_callback_id),
      .req_user_word      (req_user_word),
      .req_with_param     (req_with_param),
      .req_task_key       (req_task_key),
      .rsp_status         (rsp_status),
      .rsp_out_key        (rsp_out_key),
      .rsp_out_callback   (rsp_out_callback),
      .rsp_out_user_word  (rsp_out_user_word),
      .rsp_out_with_param (rsp_out_with_param),
      .rsp_last           (rsp_last)
   );

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import dtt_pkg::*;

   localparam int SLOTS       = TABLE_DEPTH;
   localparam int STALL_LIMIT = 6000;

   typedef struct {
      logic [2:0]  status;
      logic [30:0] key;
      logic [31:0] callback;
      logic [31:0] user_word;
      logic        with_param;
      logic        last;
   } task_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd = CMD_ADD;
   logic [63:0] req_now_ns = '0;
   logic [31:0] req_delay_ms = '0;
   logic [31:0] req_callback_id = '0;
   logic [31:0] req_user_word = '0;
   logic        req_with_param = 1'b0;
   logic [30:0] req_task_key = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic [2:0]  rsp_status;
   logic [30:0] rsp_out_key;
   logic [31:0] rsp_out_callback;
   logic [31:0] rsp_out_user_word;
   logic        rsp_out_with_param;
   logic        rsp_last;

   // shadow copy of the task table
   logic        tbl_used [SLOTS];
   logic [30:0] tbl_key [SLOTS];
   logic [63:0] tbl_deadline [SLOTS];
   logic [31:0] tbl_callback [SLOTS];
   logic [31:0] tbl_user_word [SLOTS];
   logic        tbl_with_param [SLOTS];
   logic [30:0] key_counter = '0;

   task_rsp_type pending_rsp[$];
   int          errors = 0;
   int          idle_cycles = 0;
   bit          quiet = 0;
   logic [63:0] sim_now = 64'd5000000;

   deadline_task_table uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void push_rsp(logic [2:0] st, logic [30:0] k, logic [31:0] cb,
                                    logic [31:0] uw, logic wp, logic lst);
      task_rsp_type r;
      r.status = st; r.key = k; r.callback = cb;
      r.user_word = uw; r.with_param = wp; r.last = lst;
      pending_rsp.insert(pending_rsp.size(), r);
   endfunction

   // emit and clear selected entries in ascending key order, then done
   function automatic void drain_table(bit only_due, logic [63:0] now);
      bit pick [SLOTS];
      int best;
      for (int i = 0; i < SLOTS; i++)
         pick[i] = tbl_used[i] && (!only_due || now > tbl_deadline[i]);
      forever begin
         best = -1;
         for (int i = 0; i < SLOTS; i++)
            if (pick[i] && (best < 0 || tbl_key[i] < tbl_key[best]))
               best = i;
         if (best < 0)
            break;
         push_rsp(ST_EMIT, tbl_key[best], tbl_callback[best], tbl_user_word[best],
                  tbl_with_param[best], 1'b0);
         pick[best] = 0;
         tbl_used[best] = 1'b0;
      end
      push_rsp(ST_DONE, '0, '0, '0, 1'b0, 1'b1);
   endfunction

   function automatic void predict_table(logic [1:0] cmd, logic [63:0] now, logic [31:0] dly,
                                         logic [31:0] cb, logic [31:0] uw, logic wp,
                                         logic [30:0] k);
      int slot;
      bit hit;
      logic [51:0] prod;
      logic [64:0] sum;
      slot = -1;
      hit = 0;
      case (cmd)
         CMD_ADD: begin
            for (int i = 0; i < SLOTS; i++)
               if (slot < 0 && tbl_used[i] && tbl_key[i] == key_counter)
                  slot = i;
            for (int i = 0; i < SLOTS; i++)
               if (slot < 0 && !tbl_used[i])
                  slot = i;
            if (slot < 0) begin
               push_rsp(ST_FULL, '0, '0, '0, 1'b0, 1'b1);
            end else begin
               prod = 52'(dly) * 52'd1000000;
               sum = {1'b0, now} + 65'(prod >> 10);
               tbl_used[slot] = 1'b1;
               tbl_key[slot] = key_counter;
               tbl_deadline[slot] = sum[64] ? '1 : sum[63:0];
               tbl_callback[slot] = cb;
               tbl_user_word[slot] = wp ? uw : '0;
               tbl_with_param[slot] = wp;
               push_rsp(ST_ADDED, key_counter, '0, '0, 1'b0, 1'b1);
               key_counter = key_counter + 31'd1;
            end
         end
         CMD_REMOVE: begin
            for (int i = 0; i < SLOTS; i++)
               if (tbl_used[i] && tbl_key[i] == k) begin
                  tbl_used[i] = 1'b0;
                  hit = 1;
               end
            push_rsp(hit ? ST_REMOVED : ST_ABSENT, k, '0, '0, 1'b0, 1'b1);
         end
         CMD_RUN: drain_table(1, now);
         default: drain_table(0, now);
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 9);
      if (quiet || r < 6)
         return quiet ? 0 : $urandom_range(0, 2);
      else if (r < 9)
         return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   // one request transfer; prediction at the accepting edge
   task automatic send_req(logic [1:0] cmd, logic [63:0] now, logic [31:0] dly,
                           logic [31:0] cb, logic [31:0] uw, logic wp, logic [30:0] k);
      @(posedge clock);
      repeat (pick_gap()) @(posedge clock);
      req_cmd <= cmd;
      req_now_ns <= now;
      req_delay_ms <= dly;
      req_callback_id <= cb;
      req_user_word <= uw;
      req_with_param <= wp;
      req_task_key <= k;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_table(cmd, now, dly, cb, uw, wp, k);
      req_valid <= 1'b0;
   endtask

   task automatic add_task(logic [63:0] now, logic [31:0] dly);
      send_req(CMD_ADD, now, dly, $urandom, $urandom, 1'($urandom_range(0, 1)),
               31'($urandom));
   endtask

   task automatic wait_drained();
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // response check
   always @(posedge clock) begin
      task_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response status=%0d key=%0d", $time, rsp_status,
                     rsp_out_key);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_status !== want.status || rsp_out_key !== want.key ||
                rsp_out_callback !== want.callback || rsp_out_user_word !== want.user_word ||
                rsp_out_with_param !== want.with_param || rsp_last !== want.last) begin
               $display("%0t: mismatch expected st=%0d key=%0d cb=%h uw=%h wp=%b last=%b",
                        $time, want.status, want.key, want.callback, want.user_word,
                        want.with_param, want.last);
               $display("%0t:          actual   st=%0d key=%0d cb=%h uw=%h wp=%b last=%b",
                        $time, rsp_status, rsp_out_key, rsp_out_callback, rsp_out_user_word,
                        rsp_out_with_param, rsp_last);
               errors++;
            end
         end
      end
   end

   // receiver stalls: mostly short, sometimes long
   always @(posedge clock) begin
      static int stall_left = 0;
      if (reset || quiet) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 49) == 0) begin
         stall_left = $urandom_range(20, 60);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // watchdog on transfer activity
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // extremes of fields, all commands, remove hit and miss
   task automatic test_basic();
      send_req(CMD_ADD, '0, '0, '0, '1, 1'b0, '0);
      send_req(CMD_ADD, '1, '1, '1, '1, 1'b1, '1);
      send_req(CMD_ADD, 64'd1000, 32'd5, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 1'b1, '0);
      send_req(CMD_REMOVE, '0, '0, '0, '0, 1'b0, 31'd1);
      send_req(CMD_REMOVE, '0, '0, '0, '0, 1'b0, 31'd1);
      send_req(CMD_REMOVE, '0, '0, '0, '0, 1'b0, '1);
      send_req(CMD_RUN, 64'd2000000, '0, '0, '0, 1'b0, '0);
      send_req(CMD_FINISH, '0, '0, '0, '0, 1'b0, '0);
   endtask

   // deadline equal to now is not due; saturated deadline never due
   task automatic test_deadline_edges();
      send_req(CMD_ADD, 64'd1000, 32'd1024, 32'd7, 32'd9, 1'b1, '0);
      send_req(CMD_ADD, '1, '1, 32'd8, 32'd10, 1'b0, '0);
      send_req(CMD_ADD, 64'hFFFF_FFFF_FFF0_0000, 32'h0010_0000, 32'd11, 32'd12, 1'b1, '0);
      send_req(CMD_RUN, 64'd1001000, '0, '0, '0, 1'b0, '0);
      send_req(CMD_RUN, 64'd1001001, '0, '0, '0, 1'b0, '0);
      send_req(CMD_RUN, '1, '0, '0, '0, 1'b0, '0);
      send_req(CMD_FINISH, '0, '0, '0, '0, 1'b0, '0);
   endtask

   // fill all slots, overflow, free one, refill lowest free slot
   task automatic test_full_table();
      for (int i = 0; i < SLOTS; i++)
         add_task(sim_now, $urandom_range(0, 4000));
      add_task(sim_now, 32'd1);
      send_req(CMD_REMOVE, '0, '0, '0, '0, 1'b0, tbl_key[5]);
      add_task(sim_now, 32'd2);
      add_task(sim_now, 32'd3);
      send_req(CMD_RUN, sim_now + 64'd2000000, '0, '0, '0, 1'b0, '0);
      send_req(CMD_FINISH, '0, '0, '0, '0, 1'b0, '0);
   endtask

   task automatic test_random(int count);
      int r, live;
      logic [30:0] k;
      for (int n = 0; n < count; n++) begin
         if (n % 60 == 0)
            quiet = ($urandom_range(0, 2) == 0);
         if ($urandom_range(0, 40) == 0)
            wait_drained();
         r = $urandom_range(0, 99);
         sim_now = sim_now + 64'($urandom_range(0, 3000000));
         if (r < 50) begin
            if ($urandom_range(0, 15) == 0)
               add_task(64'($urandom), $urandom);
            else
               add_task(sim_now, $urandom_range(0, 20000));
         end else if (r < 68) begin
            live = -1;
            for (int i = 0; i < SLOTS; i++)
               if (tbl_used[i] && (live < 0 || $urandom_range(0, 1)))
                  live = i;
            k = (live >= 0 && $urandom_range(0, 4) != 0) ? tbl_key[live] : 31'($urandom);
            send_req(CMD_REMOVE, 64'($urandom), $urandom, $urandom, $urandom,
                     1'($urandom_range(0, 1)), k);
         end else if (r < 93) begin
            send_req(CMD_RUN, sim_now, $urandom, $urandom, $urandom,
                     1'($urandom_range(0, 1)), 31'($urandom));
         end else begin
            send_req(CMD_FINISH, {$urandom, $urandom}, $urandom, $urandom, $urandom,
                     1'($urandom_range(0, 1)), 31'($urandom));
         end
      end
      quiet = 0;
      send_req(CMD_FINISH, '0, '0, '0, '0, 1'b0, '0);
   endtask

   initial begin
      for (int i = 0; i < SLOTS; i++)
         tbl_used[i] = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_basic();
      test_deadline_edges();
      test_full_table();
      wait_drained();
      test_random(320);
      wait_drained();
      repeat (60) @(posedge clock);
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
